>>> hw/rtl/replay_and_drift_admission_check_macros.svh
// Assertion macros used by the admission check RTL.
`ifndef REPLAY_AND_DRIFT_ADMISSION_CHECK_MACROS_SVH
`define REPLAY_AND_DRIFT_ADMISSION_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("admission check assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("admission check assertion failed");

`endif

>>> hw/rtl/rdac_pkg.sv
package rdac_pkg;

    localparam int WINDOW_DEPTH = 64;

    localparam int NONCE_W  = 64;
    localparam int TIME_W   = 63;
    localparam int LIMIT_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] DRIFT_LIMIT_RESET = 32'd5000;

    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DRIFT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SIGFAIL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REUSED  = 2'd3;

    // One window slot as it moves along the cell chain.
    typedef struct packed {
        logic               valid;
        logic [NONCE_W-1:0] nonce;
    } t_entry;

    // Control from the decision logic to the window.
    typedef struct packed {
        logic               shift;
        logic [NONCE_W-1:0] key;
    } t_win_ctl;

endpackage

>>> hw/rtl/rdac_if.sv
interface rdac_req_if;
    logic                        valid;
    logic                        ready;
    logic [rdac_pkg::NONCE_W-1:0] nonce;
    logic [rdac_pkg::TIME_W-1:0]  request_time;
    logic [rdac_pkg::TIME_W-1:0]  now_time;
    logic                        signature_ok;

    modport source (output valid, nonce, request_time, now_time, signature_ok, input ready);
    modport sink   (input valid, nonce, request_time, now_time, signature_ok, output ready);
endinterface

interface rdac_resp_if;
    logic                          valid;
    logic                          ready;
    logic [rdac_pkg::STATUS_W-1:0] status;

    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

interface rdac_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rdac_pkg::LIMIT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/rdac_cell.sv
module rdac_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [rdac_pkg::NONCE_W-1:0] i_key,
    input  rdac_pkg::t_entry             i_prev,
    output rdac_pkg::t_entry             o_entry,
    output logic                         o_hit
);

    logic                         r_valid;
    logic [rdac_pkg::NONCE_W-1:0] r_nonce;
    logic                         r_hit;

    // Take the neighbor's slot on a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_shift) begin
                r_valid <= i_prev.valid;
            end
            r_hit <= r_valid && (r_nonce == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_nonce <= i_prev.nonce;
        end
    end

    assign o_entry = '{valid: r_valid, nonce: r_nonce};
    assign o_hit   = r_hit;

endmodule

>>> hw/rtl/rdac_window.sv
module rdac_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdac_pkg::t_win_ctl i_ctl,
    output logic               o_hit
);

    rdac_pkg::t_entry                  w_head;
    rdac_pkg::t_entry                  w_out  [rdac_pkg::WINDOW_DEPTH];
    logic [rdac_pkg::WINDOW_DEPTH-1:0] w_hits;

    // Newest nonce enters at cell 0; the oldest falls off the far end.
    assign w_head = '{valid: 1'b1, nonce: i_ctl.key};

    for (genvar g = 0; g < rdac_pkg::WINDOW_DEPTH; g++) begin : g_cell
        rdac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_ctl.shift),
            .i_key   (i_ctl.key),
            .i_prev  ((g == 0) ? w_head : w_out[(g == 0) ? 0 : g - 1]),
            .o_entry (w_out[g]),
            .o_hit   (w_hits[g])
        );
    end

    assign o_hit = |w_hits;

endmodule

>>> hw/rtl/replay_and_drift_admission_check.sv
// Channel   Port    Dir  Payload
// request   i_req   in   nonce[63:0], request_time[62:0], now_time[62:0], signature_ok
// verdict   o_resp  out  status[1:0] (granted, time drift, signature fail, nonce reused)
// config    i_cfg   in   data[31:0] -> drift_limit_ms
//
// One request is in flight at a time and passes through the steps accept, cell compare and
// decide; its verdict is registered at the end of the decide step, and the next request
// is taken only once the state has returned to idle.
// A verdict waiting on o_resp holds the decide step until it is taken.
// Reset is synchronous, active low; it clears every window slot at once and
// restores drift_limit_ms to 5000. Config writes are taken in any cycle.
`include "replay_and_drift_admission_check_macros.svh"

module replay_and_drift_admission_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdac_req_if.sink   i_req,
    rdac_cfg_if.sink   i_cfg,
    rdac_resp_if.source o_resp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DEC
    } t_state;

    t_state                          r_state;
    logic [rdac_pkg::LIMIT_W-1:0]    r_drift_limit;
    logic [rdac_pkg::NONCE_W-1:0]    r_key;
    logic                            r_sig;
    logic [rdac_pkg::TIME_W:0]       r_dp;
    logic [rdac_pkg::TIME_W:0]       r_dn;
    logic                            r_drift_bad;
    logic                            r_out_valid;
    logic [rdac_pkg::STATUS_W-1:0]   r_status;

    logic [rdac_pkg::TIME_W:0]       w_abs;
    logic [rdac_pkg::STATUS_W-1:0]   w_status;
    logic                            w_slot_free;
    logic                            w_issue;
    logic                            w_hit;
    rdac_pkg::t_win_ctl              w_ctl;

    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_resp.valid = r_out_valid;
    assign o_resp.status = r_status;

    // Pick the non-negative difference; both directions of skew count.
    assign w_abs = r_dp[rdac_pkg::TIME_W] ? r_dn : r_dp;

    // Fixed check order: drift first, then signature, then replay.
    always_comb begin
        if (r_drift_bad) begin
            w_status = rdac_pkg::ST_DRIFT;
        end else if (!r_sig) begin
            w_status = rdac_pkg::ST_SIGFAIL;
        end else if (w_hit) begin
            w_status = rdac_pkg::ST_REUSED;
        end else begin
            w_status = rdac_pkg::ST_GRANTED;
        end
    end

    assign w_slot_free = !r_out_valid || o_resp.ready;
    assign w_issue     = (r_state == S_DEC) && w_slot_free;

    // Only a granted nonce enters the window.
    assign w_ctl = '{shift: w_issue && (w_status == rdac_pkg::ST_GRANTED), key: r_key};

    rdac_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_hit   (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_drift_limit <= rdac_pkg::DRIFT_LIMIT_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_drift_limit <= i_cfg.data;
            end
            // Load a new verdict, or drop the one just taken.
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (o_resp.valid && o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // Latch the transaction and form both differences.
                    if (i_req.valid && i_req.ready) begin
                        r_key   <= i_req.nonce;
                        r_sig   <= i_req.signature_ok;
                        r_dp    <= {1'b0, i_req.now_time} - {1'b0, i_req.request_time};
                        r_dn    <= {1'b0, i_req.request_time} - {1'b0, i_req.now_time};
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // Cells compare against the key in this cycle.
                    r_drift_bad <= w_abs > {{(rdac_pkg::TIME_W + 1 - rdac_pkg::LIMIT_W){1'b0}},
                                            r_drift_limit};
                    r_state     <= S_DEC;
                end
                S_DEC: begin
                    // Hold until the output register can take the verdict.
                    if (w_slot_free) begin
                        r_status    <= w_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RDAC_ASSERT_SAME(a_shift_only_on_clean_grant, i_clk, i_rst_n, w_ctl.shift,
                      (r_state == S_DEC) && r_sig && !r_drift_bad && !w_hit)
    `RDAC_ASSERT_NEXT(a_accept_starts_compare, i_clk, i_rst_n,
                      i_req.valid && i_req.ready, r_state == S_CMP)
    `RDAC_ASSERT_SAME(a_verdict_from_decide, i_clk, i_rst_n,
                      $rose(r_out_valid), $past(r_state) == S_DEC)

endmodule
